>>> design/ket_pkg.sv
// Shared types and codes for the keyed entry table.
package ket_pkg;

    // Operation codes carried in a request
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd4;

    localparam int KEY_W = 64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] id_high;
        logic [31:0] id_low;
        logic [4:0]  slot_index;
    } t_request;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] found_slot;
        logic [5:0] entry_count;
    } t_result;

endpackage

>>> design/ket_mem.sv
// Identifier memory: one write port, one read port with registered read data.
module ket_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [ket_pkg::KEY_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [ket_pkg::KEY_W-1:0] o_rd_data
);

    logic [ket_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [ket_pkg::KEY_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ket_ctrl.sv
// Sequencer: decodes requests, scans and compacts the memory, keeps the count.
module ket_ctrl #(
    parameter int MAX_ENTRIES = 32,
    parameter int ADDR_W      = 5,
    parameter int CNT_W       = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  ket_pkg::t_request         i_req,
    output logic                      o_done,
    output ket_pkg::t_result          o_result,
    output logic                      o_wr_en,
    output logic [ADDR_W-1:0]         o_wr_addr,
    output logic [ket_pkg::KEY_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [ADDR_W-1:0]         o_rd_addr,
    input  logic [ket_pkg::KEY_W-1:0] i_rd_data
);

    localparam int CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FIND  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic [ket_pkg::KEY_W-1:0] r_key, n_key;
    logic                      r_done, n_done;
    ket_pkg::t_result          r_result, n_result;

    logic             accept;
    logic             last;
    logic [CMP_W-1:0] slot_w;
    logic [CMP_W-1:0] cnt_w;

    assign accept = i_start && (r_state == S_IDLE);
    assign last   = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign slot_w = CMP_W'(i_req.slot_index);
    assign cnt_w  = CMP_W'(r_count);

    // next-state and memory port control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_done    = 1'b0;
        n_result  = r_result;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx - ADDR_W'(1);
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx + ADDR_W'(1);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done              = 1'b1;
                    n_result.status     = ket_pkg::ST_OK;
                    n_result.found_slot = '0;
                    n_key               = {i_req.id_high, i_req.id_low};
                    case (i_req.operation)
                        ket_pkg::OP_FIND: begin
                            if (r_count == '0) begin
                                n_result.status = ket_pkg::ST_NOT_FOUND;
                            end else begin
                                n_done    = 1'b0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_idx     = '0;
                                n_state   = S_FIND;
                            end
                        end
                        ket_pkg::OP_ADD: begin
                            if (r_count == CNT_W'(MAX_ENTRIES)) begin
                                n_result.status = ket_pkg::ST_FULL;
                            end else begin
                                o_wr_en             = 1'b1;
                                o_wr_addr           = ADDR_W'(r_count);
                                o_wr_data           = {i_req.id_high, i_req.id_low};
                                n_count             = r_count + CNT_W'(1);
                                n_result.found_slot = 5'(r_count);
                            end
                        end
                        ket_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_result.status = ket_pkg::ST_EMPTY;
                            end else if (slot_w >= cnt_w) begin
                                n_result.status = ket_pkg::ST_BAD_SLOT;
                            end else if (slot_w + CMP_W'(1) == cnt_w) begin
                                // last entry: nothing to move
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_done    = 1'b0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = ADDR_W'(i_req.slot_index) + ADDR_W'(1);
                                n_idx     = ADDR_W'(i_req.slot_index) + ADDR_W'(1);
                                n_state   = S_SHIFT;
                            end
                        end
                        default: begin
                            n_result.status = ket_pkg::ST_BAD_SLOT;
                        end
                    endcase
                end
            end

            // read data holds entry r_idx; compare and fetch the next one
            S_FIND: begin
                if (i_rd_data == r_key) begin
                    n_done              = 1'b1;
                    n_result.found_slot = 5'(r_idx);
                    n_state             = S_IDLE;
                end else if (last) begin
                    n_done          = 1'b1;
                    n_result.status = ket_pkg::ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + ADDR_W'(1);
                end
            end

            // move entry r_idx down one slot while the next is read
            S_SHIFT: begin
                o_wr_en = 1'b1;
                if (last) begin
                    n_done  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end else begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + ADDR_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_result.entry_count = 6'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> design/keyed_entry_table_unit.sv
// Top level of the keyed entry table: sequencer plus identifier memory.
//
// Usage: a packed table of 64-bit identifiers held in one synchronous memory.
// A request is taken on a rising edge with start high and busy low; its
// operation is find, add or remove. Exactly one result per request appears
// on o_result for a single cycle, flagged by o_done; there is no back
// pressure, so the receiver must take it in that cycle.
// Add, removal of the last entry and any request that fails its checks are
// answered without raising busy; the next request may be taken in the
// following cycle. Find reads entries upward from slot 0 and answers on the
// first match, or after the last entry on a miss. Remove of slot s moves
// each entry above s down one slot, then answers.
// Find and remove step through the memory one entry per cycle, set by its
// single read port with registered read data. busy stays high until the
// result is flagged.
// Reset empties the table (count to zero); memory contents are not cleared.
module keyed_entry_table_unit #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ket_pkg::t_request i_req,
    output logic              o_done,
    output ket_pkg::t_result  o_result
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ket_pkg::KEY_W-1:0] wr_data;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ket_pkg::KEY_W-1:0] rd_data;

    // request sequencing and count
    ket_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_req     (i_req),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // identifier storage
    ket_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

>>> design/ket_chk.sv
// Port-level checks for the keyed entry table, bound to the top level.
module ket_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input ket_pkg::t_result  o_result
);

    // an accepted request is either in progress or answered next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request neither busy nor answered");

    // a result is only flagged once the block is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result flagged while busy");

    // failed requests report slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ket_pkg::ST_OK)) |-> (o_result.found_slot == '0))
        else $error("failed request with nonzero slot");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= ket_pkg::ST_BAD_SLOT))
        else $error("undefined status code");

    // the block leaves reset idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!busy && !o_done))
        else $error("not idle after reset");

endmodule

bind keyed_entry_table_unit ket_chk u_ket_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

>>> test/keyed_entry_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyed entry table: directed and random requests, scoreboard.
module keyed_entry_table_unit_tb;

    localparam int TABLE_DEPTH = 32;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 64;

    // one queued request, or a hold point where the sender waits for all results
    typedef struct {
        ket_pkg::t_request req;
        bit                hold;
        int                idle_pct;
    } t_queued_request;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    ket_pkg::t_request i_req = '0;
    logic              o_done;
    ket_pkg::t_result  o_result;

    t_queued_request  request_q[$];
    ket_pkg::t_result outcome_q[$];

    // predictor state
    logic [ket_pkg::KEY_W-1:0] model_ids[TABLE_DEPTH];
    int unsigned               model_count = 0;

    // stimulus bookkeeping
    logic [ket_pkg::KEY_W-1:0] key_pool[16];
    int unsigned               gen_count = 0;
    int                        item_total = 0;
    int                        sent_count = 0;
    int                        mismatch_count = 0;
    int                        stall_cycles = 0;

    keyed_entry_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // apply one request to the table copy and return the outcome it yields
    function automatic ket_pkg::t_result table_step(ket_pkg::t_request r);
        ket_pkg::t_result          res;
        logic [ket_pkg::KEY_W-1:0] key;
        int unsigned               s;
        res = '0;
        key = {r.id_high, r.id_low};
        case (r.operation)
            ket_pkg::OP_FIND: begin
                res.status = ket_pkg::ST_NOT_FOUND;
                // scan downward so the lowest match wins
                for (int k = int'(model_count) - 1; k >= 0; k--) begin
                    if (model_ids[k] == key) begin
                        res.status = ket_pkg::ST_OK;
                        res.found_slot = 5'(k);
                    end
                end
            end
            ket_pkg::OP_ADD: begin
                if (model_count >= TABLE_DEPTH) begin
                    res.status = ket_pkg::ST_FULL;
                end else begin
                    model_ids[model_count] = key;
                    res.found_slot = 5'(model_count);
                    model_count++;
                    res.status = ket_pkg::ST_OK;
                end
            end
            ket_pkg::OP_REMOVE: begin
                s = 32'(r.slot_index);
                if (model_count == 0) begin
                    res.status = ket_pkg::ST_EMPTY;
                end else if (s >= model_count) begin
                    res.status = ket_pkg::ST_BAD_SLOT;
                end else begin
                    // close the gap left by the removed slot
                    for (int unsigned k = s; k + 1 < model_count; k++)
                        model_ids[k] = model_ids[k + 1];
                    model_count--;
                    res.status = ket_pkg::ST_OK;
                end
            end
            default: res.status = ket_pkg::ST_BAD_SLOT;
        endcase
        res.entry_count = 6'(model_count);
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic queue_request(logic [1:0] op, logic [ket_pkg::KEY_W-1:0] key,
                                 logic [4:0] slot, int idle_pct);
        t_queued_request q;
        q.req.operation  = op;
        q.req.id_high    = key[63:32];
        q.req.id_low     = key[31:0];
        q.req.slot_index = slot;
        q.hold           = 1'b0;
        q.idle_pct       = idle_pct;
        request_q.push_back(q);
        item_total++;
        // track occupancy so removes can aim at live slots
        if (op == ket_pkg::OP_ADD && gen_count < TABLE_DEPTH)
            gen_count++;
        else if (op == ket_pkg::OP_REMOVE && gen_count > 0 && slot < gen_count)
            gen_count--;
    endtask

    task automatic queue_hold();
        t_queued_request q;
        q.req      = '0;
        q.hold     = 1'b1;
        q.idle_pct = 0;
        request_q.push_back(q);
    endtask

    // keys come mostly from a small pool so hits and duplicates are common
    function automatic logic [ket_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(15)];
        return {$urandom, $urandom};
    endfunction

    // random traffic in bursts that lean toward filling or draining the table
    task automatic queue_random(int count, int idle_pct);
        int                        add_pct;
        int                        burst_left;
        int                        r;
        logic [1:0]                op;
        logic [ket_pkg::KEY_W-1:0] key;
        logic [4:0]                slot;
        burst_left = 0;
        add_pct = 45;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(80, 30);
                case ($urandom_range(2))
                    0:       add_pct = 75;
                    1:       add_pct = 45;
                    default: add_pct = 20;
                endcase
            end
            burst_left--;
            if ($urandom_range(99) < 5)
                key_pool[$urandom_range(15, 2)] = {$urandom, $urandom};
            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNKNOWN;
            else if (r < 3 + add_pct)
                op = ket_pkg::OP_ADD;
            else if ($urandom_range(4) < 3)
                op = ket_pkg::OP_FIND;
            else
                op = ket_pkg::OP_REMOVE;
            key = (op == ket_pkg::OP_FIND || op == ket_pkg::OP_ADD) ? pick_key()
                                                                    : {$urandom, $urandom};
            if (op == ket_pkg::OP_REMOVE && gen_count > 0 && $urandom_range(99) < 85)
                slot = 5'($urandom_range(gen_count - 1, 0));
            else
                slot = 5'($urandom_range(31));
            queue_request(op, key, slot, idle_pct);
            if ($urandom_range(99) < 2)
                queue_hold();
        end
    endtask

    // driver: sample the handshake, predict accepted requests, present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                outcome_q.push_back(table_step(i_req));
                sent_count++;
            end
            if (!start || !busy) begin
                if (request_q.size() == 0) begin
                    start <= 1'b0;
                end else if (request_q[0].hold) begin
                    start <= 1'b0;
                    if (outcome_q.size() == 0)
                        void'(request_q.pop_front());
                end else if ($urandom_range(99) < request_q[0].idle_pct) begin
                    start <= 1'b0;
                end else begin
                    i_req <= request_q[0].req;
                    start <= 1'b1;
                    void'(request_q.pop_front());
                end
            end
        end
    end

    // monitor: compare each flagged result with the oldest outcome
    always @(posedge i_clk) begin
        ket_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                flag_mismatch($sformatf("result with no request outstanding (status %0d)",
                                        o_result.status));
            end else begin
                want = outcome_q.pop_front();
                if (o_result.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            o_result.status, want.status));
                if (o_result.found_slot !== want.found_slot)
                    flag_mismatch($sformatf("found_slot %0d, want %0d",
                                            o_result.found_slot, want.found_slot));
                if (o_result.entry_count !== want.entry_count)
                    flag_mismatch($sformatf("entry_count %0d, want %0d",
                                            o_result.entry_count, want.entry_count));
            end
        end
    end

    // watchdog on cycles where neither a request nor a result moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("keyed_entry_table_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 16; k++)
            key_pool[k] = {$urandom, $urandom};

        // directed: empty-table cases, extremes, duplicates, compaction
        queue_request(ket_pkg::OP_FIND,   64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd0, 38);
        queue_request(OP_UNKNOWN,         '1,    5'd31, 38);
        queue_request(ket_pkg::OP_ADD,    64'h0, 5'd31, 38);
        queue_request(ket_pkg::OP_ADD,    '1,    5'd0, 38);
        queue_request(ket_pkg::OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 5'd0, 38);
        queue_request(ket_pkg::OP_ADD,    64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   '1,    5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   64'h5555_5555_5555_5555, 5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   64'h1, 5'd0, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd31, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd4, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd2, 38);
        queue_request(ket_pkg::OP_ADD,    64'h5555_5555_5555_5555, 5'd0, 38);
        queue_request(ket_pkg::OP_REMOVE, 64'h0, 5'd1, 38);
        queue_request(ket_pkg::OP_FIND,   64'h5555_5555_5555_5555, 5'd0, 38);
        queue_request(OP_UNKNOWN,         64'h0, 5'd0, 38);
        queue_request(ket_pkg::OP_ADD,    64'hFFFF_FFFF_0000_0000, 5'd0, 38);
        queue_request(ket_pkg::OP_FIND,   64'hFFFF_FFFF_0000_0000, 5'd0, 38);
        queue_hold();

        // random traffic under three sender pacing regimes
        queue_random(626, 38);
        queue_hold();
        queue_random(626, 66);
        queue_hold();
        queue_random(626, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count != item_total || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

        if (mismatch_count == 0) begin
            $display("keyed_entry_table_unit_tb OK");
        end else begin
            $display("keyed_entry_table_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
